// ===== src/j2gw_pkg.sv =====
`default_nettype none
package j2gw_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int DIV_STAGES        = 63;
    localparam int POST_STAGES       = 9;

    localparam int ANG_W = 36;   // angle width during range reduction
    localparam int CW    = 34;   // CORDIC datapath, Q2.30 plus headroom
    localparam int MAG_W = 33;   // magnitudes of sin/cos products

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;

    localparam logic [62:0] MAG63_MAX = '1;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    localparam logic [62:0] GM_RESET  = 63'd398600441800000;
    localparam logic [31:0] REF_RESET = 32'd6378137;
    localparam logic [31:0] J2_RESET  = 32'd4649890;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GM         = 2'd0,
        CFG_REF_RADIUS = 2'd1,
        CFG_J2         = 2'd2
    } t_cfg_idx;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    typedef struct packed {
        logic zero;
        logic sat;
        logic fneg;
        logic pneg;
    } t_flags;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        logic signed [CW-1:0] v;
        v = '0;
        if (i < 10) begin
            case (i)
                0: v = 34'sd843314856;
                1: v = 34'sd497837829;
                2: v = 34'sd263043836;
                3: v = 34'sd133525158;
                4: v = 34'sd67021686;
                5: v = 34'sd33543515;
                6: v = 34'sd16775850;
                7: v = 34'sd8388437;
                8: v = 34'sd4194282;
                default: v = 34'sd2097149;
            endcase
        end else if (i < 30) begin
            v = CW'((64'd1 << (30 - i)) - 64'd1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/j2gw_in_if.sv =====
`default_nettype none
interface j2gw_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] radius;
    logic signed [31:0] latitude;

    modport source (output valid, radius, latitude, input ready);
    modport sink   (input valid, radius, latitude, output ready);
endinterface
`default_nettype wire

// ===== src/j2gw_out_if.sv =====
`default_nettype none
interface j2gw_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] radial_weight;
    logic signed [63:0] latitudinal_weight;
    logic        [1:0]  status;

    modport source (output valid, radial_weight, latitudinal_weight, status, input ready);
    modport sink   (input valid, radial_weight, latitudinal_weight, status, output ready);
endinterface
`default_nettype wire

// ===== src/j2_gravity_weight_unit.sv =====
`default_nettype none
// J2 gravity weight: a sustained rate of one request per clock while not
// stalled. Requests pass an input register, a 63-stage restoring divider
// producing one quotient bit per stage, then nine multiply/assemble
// stages. The CORDIC runs beside the divider; its length (CORDIC_STAGES,
// 16..48) does not change latency. Backpressure stalls the whole
// pipeline: ready is high whenever the output register is empty or
// being taken. The user must write registers through the plain write
// port only while no request is in flight; the block does not enforce it.
module j2_gravity_weight_unit #(
    parameter int CORDIC_STAGES = j2gw_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [j2gw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [62:0]                      i_cfg_data,
    j2gw_in_if.sink                               i_in,
    j2gw_out_if.source                            o_out
);
    localparam int LAT      = 1 + j2gw_pkg::DIV_STAGES + j2gw_pkg::POST_STAGES;
    localparam int MW       = j2gw_pkg::MAG_W;
    localparam int CW       = j2gw_pkg::CW;
    localparam int TRIG_PAD = j2gw_pkg::DIV_STAGES - CORDIC_STAGES - 2;
    localparam int TRIG_W   = 2 + 2 * MW;

    logic [62:0]    r_gm;
    logic [31:0]    r_ref;
    logic [31:0]    r_j2;
    logic [LAT-1:0] r_vld;
    logic           w_en;

    logic [63:0] r_r2, r_rr2;
    logic        r_zero;
    logic        sat_b, sat_q;
    logic [63:0] rem_b, rem_q;

    logic [62:0] quo_b, quo_q;
    logic [2:0]  flg_d;

    logic signed [CW-1:0] c_sin, c_cos;
    logic [MW-1:0] sm, cm;
    logic [65:0]   p_ss, p_sc;
    logic [MW-1:0] r_s2, r_pm1;
    logic          r_pneg1;
    logic [35:0]   s2x3;
    logic signed [35:0] f;
    logic [MW-1:0] r_fmag, r_pm2;
    logic          r_fneg, r_pneg2;
    logic [TRIG_W-1:0] trig_d;

    j2gw_pkg::t_flags flg;
    logic [62:0]      b_val, q_val;

    assign w_en        = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm  <= j2gw_pkg::GM_RESET;
            r_ref <= j2gw_pkg::REF_RESET;
            r_j2  <= j2gw_pkg::J2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                j2gw_pkg::CFG_GM:         r_gm  <= i_cfg_data;
                j2gw_pkg::CFG_REF_RADIUS: r_ref <= i_cfg_data[31:0];
                j2gw_pkg::CFG_J2:         r_j2  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2   <= {32'b0, i_in.radius} * {32'b0, i_in.radius};
            r_rr2  <= {32'b0, r_ref} * {32'b0, r_ref};
            r_zero <= i_in.radius == '0;
        end
    end

    // quotient reaches 2^63 exactly when the top part of the dividend
    // is already at least the divisor
    assign rem_b = {40'b0, r_gm[62:39]};
    assign rem_q = {31'b0, r_rr2[63:31]};
    assign sat_b = rem_b >= r_r2;
    assign sat_q = rem_q >= r_r2;

    j2gw_divider u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rem  (rem_b),
        .i_bits ({r_gm[38:0], 24'b0}),
        .i_den  (r_r2),
        .o_quo  (quo_b)
    );

    j2gw_divider u_div_q (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rem  (rem_q),
        .i_bits ({r_rr2[30:0], 32'b0}),
        .i_den  (r_r2),
        .o_quo  (quo_q)
    );

    j2gw_delay #(.WIDTH(3), .DEPTH(j2gw_pkg::DIV_STAGES)) u_flg_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data ({r_zero, sat_b, sat_q}),
        .o_data (flg_d)
    );

    j2gw_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_latitude (i_in.latitude),
        .o_sin      (c_sin),
        .o_cos      (c_cos)
    );

    always_comb begin
        sm   = c_sin[CW-1] ? MW'(-c_sin) : MW'(c_sin);
        cm   = c_cos[CW-1] ? MW'(-c_cos) : MW'(c_cos);
        p_ss = {33'b0, sm} * {33'b0, sm};
        p_sc = {33'b0, sm} * {33'b0, cm};
        s2x3 = {3'b0, r_s2} + {2'b0, r_s2, 1'b0};
        f    = 36'sd1073741824 - $signed(s2x3);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2    <= p_ss[62:30];
            r_pm1   <= p_sc[62:30];
            r_pneg1 <= c_sin[CW-1] ^ c_cos[CW-1];

            r_fneg  <= f[35];
            r_fmag  <= f[35] ? MW'(-f) : MW'(f);
            r_pm2   <= r_pm1;
            r_pneg2 <= r_pneg1;
        end
    end

    j2gw_delay #(.WIDTH(TRIG_W), .DEPTH(TRIG_PAD)) u_trig_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data ({r_fneg, r_pneg2, r_fmag, r_pm2}),
        .o_data (trig_d)
    );

    always_comb begin
        flg.zero = flg_d[2];
        flg.sat  = flg_d[1] || flg_d[0];
        flg.fneg = trig_d[TRIG_W-1];
        flg.pneg = trig_d[TRIG_W-2];
        b_val    = flg_d[1] ? j2gw_pkg::MAG63_MAX : quo_b;
        q_val    = flg_d[0] ? j2gw_pkg::MAG63_MAX : quo_q;
    end

    j2gw_post u_post (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_b      (b_val),
        .i_q      (q_val),
        .i_fmag   (trig_d[2*MW-1:MW]),
        .i_pm     (trig_d[MW-1:0]),
        .i_flg    (flg),
        .i_j2     (r_j2),
        .o_radial (o_out.radial_weight),
        .o_lat    (o_out.latitudinal_weight),
        .o_status (o_out.status)
    );
endmodule
`default_nettype wire

// ===== src/j2gw_delay.sv =====
`default_nettype none
module j2gw_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_data,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_data = r_sh[DEPTH-1];
endmodule
`default_nettype wire

// ===== src/j2gw_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage. Caller guarantees the
// initial remainder is below the divisor when the result is used.
module j2gw_divider (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rem,
    input  wire logic [62:0] i_bits,
    input  wire logic [63:0] i_den,
    output logic      [62:0] o_quo
);
    localparam int N = j2gw_pkg::DIV_STAGES;

    logic [63:0] rem_s [N+1];
    logic [62:0] nq_s  [N+1];
    logic [63:0] den_s [N+1];
    logic [63:0] r_rem [N];
    logic [62:0] r_nq  [N];
    logic [63:0] r_den [N];

    assign rem_s[0] = i_rem;
    assign nq_s[0]  = i_bits;
    assign den_s[0] = i_den;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [64:0] t;
        logic        ge;

        assign t  = {rem_s[i], nq_s[i][62]};
        assign ge = t >= {1'b0, den_s[i]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? 64'(t - {1'b0, den_s[i]}) : t[63:0];
                r_nq[i]  <= {nq_s[i][61:0], ge};
                r_den[i] <= den_s[i];
            end
        end

        assign rem_s[i+1] = r_rem[i];
        assign nq_s[i+1]  = r_nq[i];
        assign den_s[i+1] = r_den[i];
    end

    assign o_quo = nq_s[N];
endmodule
`default_nettype wire

// ===== src/j2gw_cordic.sv =====
`default_nettype none
module j2gw_cordic #(
    parameter int STAGES = j2gw_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [31:0]                i_latitude,
    output logic signed      [j2gw_pkg::CW-1:0]    o_sin,
    output logic signed      [j2gw_pkg::CW-1:0]    o_cos
);
    localparam int AW = j2gw_pkg::ANG_W;
    localparam int CW = j2gw_pkg::CW;

    logic signed [AW-1:0] a0, a1, a2;
    logic                 flip;
    logic signed [CW-1:0] r_ang;
    logic [STAGES:0]      r_flip;

    logic signed [CW-1:0] x_s [STAGES+1];
    logic signed [CW-1:0] y_s [STAGES+1];
    logic signed [CW-1:0] z_s [STAGES+1];
    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];

    // Q3.28 -> Q.30, one wrap by 2*pi covers the input range, then fold
    // into [-pi/2, pi/2] with cos negated
    always_comb begin
        a0 = {{(AW-34){i_latitude[31]}}, i_latitude, 2'b00};
        if (a0 > j2gw_pkg::PI_Q30) begin
            a1 = a0 - j2gw_pkg::TWO_PI_Q30;
        end else if (a0 < -j2gw_pkg::PI_Q30) begin
            a1 = a0 + j2gw_pkg::TWO_PI_Q30;
        end else begin
            a1 = a0;
        end
        flip = 1'b1;
        if (a1 > j2gw_pkg::HALF_PI_Q30) begin
            a2 = j2gw_pkg::PI_Q30 - a1;
        end else if (a1 < -j2gw_pkg::HALF_PI_Q30) begin
            a2 = -j2gw_pkg::PI_Q30 - a1;
        end else begin
            a2   = a1;
            flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang  <= CW'(a2);
            r_flip <= {r_flip[STAGES-1:0], flip};
        end
    end

    assign x_s[0] = j2gw_pkg::CORDIC_GAIN;
    assign y_s[0] = '0;
    assign z_s[0] = r_ang;

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [CW-1:0] AT = j2gw_pkg::atan_q30(i);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_s[i][CW-1]) begin
                    r_x[i] <= x_s[i] - (y_s[i] >>> i);
                    r_y[i] <= y_s[i] + (x_s[i] >>> i);
                    r_z[i] <= z_s[i] - AT;
                end else begin
                    r_x[i] <= x_s[i] + (y_s[i] >>> i);
                    r_y[i] <= y_s[i] - (x_s[i] >>> i);
                    r_z[i] <= z_s[i] + AT;
                end
            end
        end

        assign x_s[i+1] = r_x[i];
        assign y_s[i+1] = r_y[i];
        assign z_s[i+1] = r_z[i];
    end

    assign o_sin = y_s[STAGES];
    assign o_cos = r_flip[STAGES] ? -x_s[STAGES] : x_s[STAGES];
endmodule
`default_nettype wire

// ===== src/j2gw_post.sv =====
`default_nettype none
// Weight assembly: J2 factor, both products, saturation. Nine stages.
module j2gw_post (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [62:0]                     i_b,
    input  wire logic [62:0]                     i_q,
    input  wire logic [j2gw_pkg::MAG_W-1:0]      i_fmag,
    input  wire logic [j2gw_pkg::MAG_W-1:0]      i_pm,
    input  wire j2gw_pkg::t_flags                i_flg,
    input  wire logic [31:0]                     i_j2,
    output logic signed [63:0]                   o_radial,
    output logic signed [63:0]                   o_lat,
    output j2gw_pkg::t_status                    o_status
);
    localparam int MW = j2gw_pkg::MAG_W;

    // P1
    logic [62:0] r1_kh, r1_b;
    logic [63:0] r1_kl;
    logic [MW-1:0] r1_fmag, r1_pm;
    j2gw_pkg::t_flags r1_flg;
    // P2
    logic [62:0] r2_k, r2_b;
    logic [MW-1:0] r2_fmag, r2_pm;
    j2gw_pkg::t_flags r2_flg;
    // P3
    logic [64:0] r3_kfl, r3_kpl;
    logic [63:0] r3_kfh, r3_kph;
    logic [62:0] r3_b;
    j2gw_pkg::t_flags r3_flg;
    // P4
    logic [65:0] r4_t;
    logic [63:0] r4_m;
    logic [62:0] r4_b;
    j2gw_pkg::t_flags r4_flg;
    // P5
    logic [63:0] r5_g, r5_m;
    logic        r5_gneg;
    logic [62:0] r5_b;
    j2gw_pkg::t_flags r5_flg;
    // P6
    logic [63:0] r6_rll, r6_rlh, r6_mll, r6_mlh;
    logic [62:0] r6_rhl, r6_rhh, r6_mhl, r6_mhh;
    logic        r6_gneg;
    j2gw_pkg::t_flags r6_flg;
    // P7
    logic [95:0] r7_rad, r7_lat;
    logic        r7_gneg;
    j2gw_pkg::t_flags r7_flg;
    // P8
    logic [95:0] r8_rad;
    logic [97:0] r8_lat;
    logic        r8_gneg;
    j2gw_pkg::t_flags r8_flg;
    // P9
    logic [63:0] r9_rad, r9_lat;
    j2gw_pkg::t_status r9_status;

    logic [96:0]  tf, kp;
    logic [65:0]  g;
    logic         gneg;
    logic [127:0] rs, ms;
    logic [64:0]  sr, sl;

    localparam logic [65:0] TWO32 = 66'h1_0000_0000;

    // {saturated, value}
    function automatic logic [64:0] to_s64(input logic [97:0] mag, input logic neg);
        logic [64:0] r;
        if (!neg) begin
            if (mag > {34'b0, j2gw_pkg::INT64_MAX}) r = {1'b1, j2gw_pkg::INT64_MAX};
            else r = {1'b0, mag[63:0]};
        end else begin
            if (mag > {34'b0, j2gw_pkg::INT64_MIN}) r = {1'b1, j2gw_pkg::INT64_MIN};
            else r = {1'b0, 64'd0 - mag[63:0]};
        end
        return r;
    endfunction

    always_comb begin
        tf = {1'b0, r3_kfh, 32'b0} + {32'b0, r3_kfl};
        kp = {1'b0, r3_kph, 32'b0} + {32'b0, r3_kpl};

        // G = 1 + K/2*f, sign-magnitude
        gneg = 1'b0;
        if (!r4_flg.fneg) begin
            g = r4_t + TWO32;
        end else if (r4_t <= TWO32) begin
            g = TWO32 - r4_t;
        end else begin
            g    = r4_t - TWO32;
            gneg = 1'b1;
        end

        rs = {1'b0, r6_rhh, 64'b0} + {33'b0, r6_rhl, 32'b0}
           + {32'b0, r6_rlh, 32'b0} + {64'b0, r6_rll};
        ms = {1'b0, r6_mhh, 64'b0} + {33'b0, r6_mhl, 32'b0}
           + {32'b0, r6_mlh, 32'b0} + {64'b0, r6_mll};

        sr = to_s64({2'b0, r8_rad}, r8_gneg);
        sl = to_s64(r8_lat, r8_flg.pneg && (r8_lat != '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kh   <= {32'b0, i_q[62:32]} * {31'b0, i_j2};
            r1_kl   <= {32'b0, i_q[31:0]} * {32'b0, i_j2};
            r1_b    <= i_b;
            r1_fmag <= i_fmag;
            r1_pm   <= i_pm;
            r1_flg  <= i_flg;

            r2_k    <= r1_kh + {31'b0, r1_kl[63:32]};
            r2_b    <= r1_b;
            r2_fmag <= r1_fmag;
            r2_pm   <= r1_pm;
            r2_flg  <= r1_flg;

            r3_kfl <= {33'b0, r2_k[31:0]} * {32'b0, r2_fmag};
            r3_kfh <= {33'b0, r2_k[62:32]} * {31'b0, r2_fmag};
            r3_kpl <= {33'b0, r2_k[31:0]} * {32'b0, r2_pm};
            r3_kph <= {33'b0, r2_k[62:32]} * {31'b0, r2_pm};
            r3_b   <= r2_b;
            r3_flg <= r2_flg;

            r4_t   <= tf[96:31];
            r4_m   <= kp[93:30];
            r4_b   <= r3_b;
            r4_flg <= r3_flg;

            // G stays below 2^64 for any K and |f|
            r5_g    <= g[63:0];
            r5_gneg <= gneg;
            r5_m    <= r4_m;
            r5_b    <= r4_b;
            r5_flg  <= r4_flg;

            r6_rll  <= {32'b0, r5_b[31:0]} * {32'b0, r5_g[31:0]};
            r6_rlh  <= {32'b0, r5_b[31:0]} * {32'b0, r5_g[63:32]};
            r6_rhl  <= {32'b0, r5_b[62:32]} * {31'b0, r5_g[31:0]};
            r6_rhh  <= {32'b0, r5_b[62:32]} * {31'b0, r5_g[63:32]};
            r6_mll  <= {32'b0, r5_b[31:0]} * {32'b0, r5_m[31:0]};
            r6_mlh  <= {32'b0, r5_b[31:0]} * {32'b0, r5_m[63:32]};
            r6_mhl  <= {32'b0, r5_b[62:32]} * {31'b0, r5_m[31:0]};
            r6_mhh  <= {32'b0, r5_b[62:32]} * {31'b0, r5_m[63:32]};
            r6_gneg <= r5_gneg;
            r6_flg  <= r5_flg;

            r7_rad  <= rs[127:32];
            r7_lat  <= ms[127:32];
            r7_gneg <= r6_gneg;
            r7_flg  <= r6_flg;

            r8_rad  <= r7_rad;
            r8_lat  <= {1'b0, r7_lat, 1'b0} + {2'b0, r7_lat};
            r8_gneg <= r7_gneg;
            r8_flg  <= r7_flg;

            if (r8_flg.zero) begin
                r9_rad    <= '0;
                r9_lat    <= '0;
                r9_status <= j2gw_pkg::ST_ZERO;
            end else begin
                r9_rad    <= sr[63:0];
                r9_lat    <= sl[63:0];
                r9_status <= (r8_flg.sat || sr[64] || sl[64]) ? j2gw_pkg::ST_SAT
                                                              : j2gw_pkg::ST_OK;
            end
        end
    end

    assign o_radial = r9_rad;
    assign o_lat    = r9_lat;
    assign o_status = r9_status;
endmodule
`default_nettype wire

// ===== src/j2gw_checker.sv =====
`default_nettype none
module j2gw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_radial,
    input wire logic [63:0] i_lat,
    input wire logic [1:0]  i_status
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("request ready does not track the output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_radial)
            && $stable(i_lat) && $stable(i_status))
        else $error("stalled result changed");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == j2gw_pkg::ST_ZERO |-> i_radial == '0 && i_lat == '0)
        else $error("zero radius with nonzero weight");
endmodule

bind j2_gravity_weight_unit j2gw_checker u_j2gw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_radial    (o_out.radial_weight),
    .i_lat       (o_out.latitudinal_weight),
    .i_status    (o_out.status)
);
`default_nettype wire

// ===== test/j2_gravity_weight_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module j2_gravity_weight_unit_test;

    localparam int STAGES      = j2gw_pkg::CORDIC_STAGES_DEF;
    localparam int PIPE_DEPTH  = 80;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PER_PHASE = 240;

    typedef struct {
        logic        [31:0] radius;
        logic signed [31:0] latitude;
    } t_position;

    typedef struct {
        logic signed [63:0] radial;
        logic signed [63:0] latitudinal;
        j2gw_pkg::t_status  status;
    } t_weight;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    j2gw_pkg::t_cfg_idx cfg_idx;
    logic [62:0] cfg_data;

    j2gw_in_if  in_ch ();
    j2gw_out_if out_ch ();

    j2_gravity_weight_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // local copy of the register file
    logic [62:0] gm_reg;
    logic [31:0] radius_ref_reg;
    logic [31:0] j2_reg;

    t_position pending_positions[$];
    t_weight   expected_weights[$];

    int sender_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int accepted_positions;
    int checked_weights;
    int mismatches;
    int zero_count;
    int sat_count;
    int quiet_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] atan_step(input int i);
        logic signed [63:0] v;
        v = 0;
        case (i)
            0: v = 64'sd843314856;
            1: v = 64'sd497837829;
            2: v = 64'sd263043836;
            3: v = 64'sd133525158;
            4: v = 64'sd67021686;
            5: v = 64'sd33543515;
            6: v = 64'sd16775850;
            7: v = 64'sd8388437;
            8: v = 64'sd4194282;
            9: v = 64'sd2097149;
            default: if (i < 30) v = (64'sd1 <<< (30 - i)) - 64'sd1;
        endcase
        return v;
    endfunction

    // {saturated, value}
    function automatic logic [64:0] clamp_weight(input logic [127:0] mag, input bit neg);
        logic [64:0] res;
        if (!neg) begin
            if (mag > 128'(j2gw_pkg::INT64_MAX)) res = {1'b1, j2gw_pkg::INT64_MAX};
            else res = {1'b0, mag[63:0]};
        end else begin
            if (mag > 128'(j2gw_pkg::INT64_MIN)) res = {1'b1, j2gw_pkg::INT64_MIN};
            else res = {1'b0, 64'd0 - mag[63:0]};
        end
        return res;
    endfunction

    function automatic t_weight predict_weight(input t_position p);
        t_weight w;
        logic [127:0] r2, b, q, k, t, g, prod;
        logic signed [63:0] a, x, y, z, dx, dy, at, s, c, f;
        logic [63:0] sm, cm, s2, pm, fmag, m1;
        logic [64:0] cl;
        bit flip, fneg, gneg, pneg, sat;
        flip = 0; gneg = 0; sat = 0;
        if (p.radius == 0) begin
            w.radial = 0;
            w.latitudinal = 0;
            w.status = j2gw_pkg::ST_ZERO;
            return w;
        end
        r2 = 128'(p.radius) * 128'(p.radius);
        b = (128'(gm_reg) << 24) / r2;
        if (b > 128'(j2gw_pkg::INT64_MAX)) begin
            b = 128'(j2gw_pkg::INT64_MAX);
            sat = 1;
        end
        q = ((128'(radius_ref_reg) * 128'(radius_ref_reg)) << 32) / r2;
        if (q > 128'(j2gw_pkg::INT64_MAX)) begin
            q = 128'(j2gw_pkg::INT64_MAX);
            sat = 1;
        end
        k = (q * 128'(j2_reg)) >> 32;

        a = p.latitude;
        a = a * 4;
        while (a > 64'sd3373259426) a = a - 64'sd6746518852;
        while (a < -64'sd3373259426) a = a + 64'sd6746518852;
        if (a > 64'sd1686629713) begin
            a = 64'sd3373259426 - a;
            flip = 1;
        end else if (a < -64'sd1686629713) begin
            a = -64'sd3373259426 - a;
            flip = 1;
        end
        x = 64'sd652032874;
        y = 0;
        z = a;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            at = atan_step(i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - at;
            end else begin
                x = x + dx; y = y - dy; z = z + at;
            end
        end
        s = y;
        c = flip ? -x : x;
        sm = s < 0 ? -s : s;
        cm = c < 0 ? -c : c;
        s2 = (sm * sm) >> 30;
        pm = (sm * cm) >> 30;
        pneg = (s < 0) != (c < 0);

        f = 64'sd1073741824 - 3 * signed'(s2);
        fneg = f < 0;
        fmag = fneg ? -f : f;
        t = (k * 128'(fmag)) >> 31;
        if (!fneg) g = t + (128'd1 << 32);
        else if (t <= (128'd1 << 32)) g = (128'd1 << 32) - t;
        else begin
            g = t - (128'd1 << 32);
            gneg = 1;
        end
        prod = (b * g) >> 32;
        cl = clamp_weight(prod, gneg);
        sat = sat | cl[64];
        w.radial = cl[63:0];

        t = k * 128'(pm);
        m1 = 64'(t >> 30);
        prod = ((b * 128'(m1)) >> 32) * 3;
        cl = clamp_weight(prod, pneg && prod != 0);
        sat = sat | cl[64];
        w.latitudinal = cl[63:0];
        w.status = sat ? j2gw_pkg::ST_SAT : j2gw_pkg::ST_OK;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            logic presented;
            presented = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                expected_weights.push_back(predict_weight(pending_positions[0]));
                void'(pending_positions.pop_front());
                accepted_positions++;
                presented = 1'b0;
            end
            if (!presented) begin
                if (pending_positions.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    in_ch.valid    <= 1'b1;
                    in_ch.radius   <= pending_positions[0].radius;
                    in_ch.latitude <= pending_positions[0].latitude;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and back-pressures the input
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (out_ch.valid && out_ch.ready && checked_weights == 1200) hold_left <= 400;
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_weights.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.radial_weight, 0);
                end else begin
                    t_weight w;
                    w = expected_weights.pop_front();
                    if (out_ch.radial_weight !== w.radial)
                        report_mismatch("radial_weight", out_ch.radial_weight, w.radial);
                    if (out_ch.latitudinal_weight !== w.latitudinal)
                        report_mismatch("latitudinal_weight", out_ch.latitudinal_weight,
                                        w.latitudinal);
                    if (out_ch.status !== w.status)
                        report_mismatch("status", 64'(out_ch.status), 64'(w.status));
                    if (w.status == j2gw_pkg::ST_ZERO) zero_count++;
                    if (w.status == j2gw_pkg::ST_SAT) sat_count++;
                end
                checked_weights++;
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (pending_positions.size() == 0 && expected_weights.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input j2gw_pkg::t_cfg_idx idx, input logic [62:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            j2gw_pkg::CFG_GM:         gm_reg = val;
            j2gw_pkg::CFG_REF_RADIUS: radius_ref_reg = val[31:0];
            default:                  j2_reg = val[31:0];
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_positions.size() != 0 || expected_weights.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic queue_position(input logic [31:0] r, input logic [31:0] lat);
        t_position p;
        p.radius = r;
        p.latitude = lat;
        pending_positions.push_back(p);
    endtask

    task automatic queue_random(input int n);
        logic [31:0] r;
        logic [31:0] lat;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       r = $urandom;
                1:       r = $urandom_range(1000, 1);
                default: r = $urandom_range(60000000, 6000000);
            endcase
            if ($urandom_range(3) != 0) lat = $urandom;
            else lat = $urandom_range(843314856) - 421657428;
            queue_position(r, lat);
        end
    endtask

    initial begin
        logic [31:0] dir_radius[5];
        logic [31:0] dir_lat[5];
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = j2gw_pkg::CFG_GM;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.radius = '0;
        in_ch.latitude = '0;
        out_ch.ready = 1'b0;
        hold_left = 0;
        accepted_positions = 0;
        checked_weights = 0;
        mismatches = 0;
        zero_count = 0;
        sat_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 32;
        recv_idle_pct = 59;
        gm_reg = j2gw_pkg::GM_RESET;
        radius_ref_reg = j2gw_pkg::REF_RESET;
        j2_reg = j2gw_pkg::J2_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero radius, quadrant and wrap angles
        dir_radius = '{32'd0, 32'd1, 32'd6378137, 32'hFFFF_FFFF, 32'd7000000};
        dir_lat = '{32'd0, 32'd421657428, -32'sd843314856, 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (dir_radius[i]) queue_position(dir_radius[i], dir_lat[(i * 3) % 5]);
        foreach (dir_lat[i]) queue_position(32'd6378137, dir_lat[i]);
        queue_position(32'd6378137, -32'sd421657428);
        queue_position(32'd6378137, 32'd210828714);
        queue_position(32'd6378137, 32'd843314856);
        queue_position(32'd100, 32'd1);
        queue_position(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(RAND_PER_PHASE);
        drain_pipeline();

        // maximum registers
        write_reg(j2gw_pkg::CFG_GM, '1);
        write_reg(j2gw_pkg::CFG_REF_RADIUS, 63'hFFFF_FFFF);
        write_reg(j2gw_pkg::CFG_J2, 63'hFFFF_FFFF);
        queue_random(RAND_PER_PHASE);
        drain_pipeline();

        sender_idle_pct = 59;
        recv_idle_pct = 32;
        write_reg(j2gw_pkg::CFG_GM, '0);
        write_reg(j2gw_pkg::CFG_REF_RADIUS, '0);
        write_reg(j2gw_pkg::CFG_J2, '0);
        queue_random(RAND_PER_PHASE / 2);
        drain_pipeline();

        write_reg(j2gw_pkg::CFG_GM, 63'({$urandom, $urandom}));
        write_reg(j2gw_pkg::CFG_REF_RADIUS, 63'($urandom));
        write_reg(j2gw_pkg::CFG_J2, 63'($urandom));
        queue_random(RAND_PER_PHASE);
        drain_pipeline();

        sender_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(j2gw_pkg::CFG_GM, j2gw_pkg::GM_RESET);
        write_reg(j2gw_pkg::CFG_REF_RADIUS, 63'(j2gw_pkg::REF_RESET));
        write_reg(j2gw_pkg::CFG_J2, 63'(j2gw_pkg::J2_RESET));
        queue_random(RAND_PER_PHASE + 120);
        drain_pipeline();

        write_reg(j2gw_pkg::CFG_GM, 63'd5972000000000000);
        write_reg(j2gw_pkg::CFG_REF_RADIUS, 63'd6371000);
        write_reg(j2gw_pkg::CFG_J2, 63'd80000000);
        queue_random(RAND_PER_PHASE);
        drain_pipeline();

        $display("covered %0d positions over six register settings and three idle patterns",
                 accepted_positions);
        $display("checked %0d results (%0d saturated, %0d zero radius), %0d mismatches",
                 checked_weights, sat_count, zero_count, mismatches);
        if (mismatches == 0 && expected_weights.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
